[rtl/core/oagc_pkg.sv]
// Package for the AWB gain calculation block: transaction types, status codes and constants.
// No dependencies.
package oagc_pkg;

  localparam int unsigned NumW     = 30;
  localparam int unsigned DenW     = 20;
  localparam logic [9:0] TypRedRst  = 10'd327;
  localparam logic [9:0] TypBlueRst = 10'd288;
  localparam logic [10:0] RatioScale = 11'd1000;
  localparam logic [10:0] UnityGain  = 11'd1024;
  localparam logic [9:0]  LightOffset = 10'd512;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTypUnset  = 3'd1,
    StNoGroup   = 3'd2,
    StZeroRatio = 3'd3,
    StZeroBase  = 3'd4
  } status_e;

  localparam logic CfgTypRed  = 1'b0;
  localparam logic CfgTypBlue = 1'b1;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] red_ratio_high;
    logic [7:0] blue_ratio_high;
    logic [7:0] light_red_high;
    logic [7:0] light_blue_high;
    logic [7:0] packed_low_bits;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  group_used;
    logic [29:0] red_gain;
    logic [29:0] green_gain;
    logic [29:0] blue_gain;
    logic        red_apply;
    logic        green_apply;
    logic        blue_apply;
  } out_t;

  // per-lane divider operand set: numerator/denominator/partial remainder/quotient
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic [DenW:0]   rem;
    logic [NumW-1:0] quo;
  } div_lane_t;

endpackage

[rtl/core/oagc_div_cell.sv]
// One restoring-division cell: retires one quotient bit per lane per cycle.
// Depends on oagc_pkg.
module oagc_div_cell #(
  parameter int unsigned Lanes = 2,
  parameter int unsigned SideW = 8
) (
  input  logic                           clk_i,
  input  logic                           valid_i,
  input  oagc_pkg::div_lane_t [Lanes-1:0] lane_i,
  input  logic [SideW-1:0]               side_i,
  output logic                           valid_o,
  output oagc_pkg::div_lane_t [Lanes-1:0] lane_o,
  output logic [SideW-1:0]               side_o
);
  import oagc_pkg::*;

  div_lane_t [Lanes-1:0] lane_d, lane_q;
  logic [SideW-1:0] side_q;
  logic valid_q;

  always_comb begin
    logic [DenW+1:0] trial;
    logic [DenW+1:0] shifted;
    for (int l = 0; l < Lanes; l++) begin
      lane_d[l] = lane_i[l];
      shifted = {lane_i[l].rem, lane_i[l].num[NumW-1]};
      trial   = shifted - {2'b00, lane_i[l].den};
      lane_d[l].num = {lane_i[l].num[NumW-2:0], 1'b0};
      if (!trial[DenW+1]) begin
        lane_d[l].rem = trial[DenW:0];
        lane_d[l].quo = {lane_i[l].quo[NumW-2:0], 1'b1};
      end else begin
        lane_d[l].rem = shifted[DenW:0];
        lane_d[l].quo = {lane_i[l].quo[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    side_q <= side_i;
    valid_q <= valid_i;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
  assign side_o  = side_q;
endmodule

[rtl/core/oagc_div_chain.sv]
// Chain of NumW division cells, one quotient bit per cell.
// Depends on oagc_pkg and oagc_div_cell.
module oagc_div_chain #(
  parameter int unsigned Lanes = 2,
  parameter int unsigned SideW = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  oagc_pkg::div_lane_t [Lanes-1:0] lane_i,
  input  logic [SideW-1:0]               side_i,
  output logic                           valid_o,
  output logic [Lanes-1:0][oagc_pkg::NumW-1:0] quo_o,
  output logic [SideW-1:0]               side_o
);
  import oagc_pkg::*;

  logic [NumW:0] vld;
  div_lane_t [NumW:0][Lanes-1:0] ln;
  logic [NumW:0][SideW-1:0] sd;
  logic [NumW-1:0] vraw;

  assign vld[0] = valid_i;
  assign ln[0]  = lane_i;
  assign sd[0]  = side_i;

  for (genvar c = 0; c < NumW; c++) begin : g_cell
    oagc_div_cell #(.Lanes(Lanes), .SideW(SideW)) u_cell (
      .clk_i  (clk_i),
      .valid_i(vld[c]),
      .lane_i (ln[c]),
      .side_i (sd[c]),
      .valid_o(vraw[c]),
      .lane_o (ln[c+1]),
      .side_o (sd[c+1])
    );
  end

  // valid bits reset so no phantom strobes after reset
  logic [NumW-1:0] vq;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq <= '0;
    end else begin
      vq <= {vq[NumW-2:0], valid_i};
    end
  end
  for (genvar c = 0; c < NumW; c++) begin : g_v
    assign vld[c+1] = vq[c] & vraw[c] | vq[c] & ~vraw[c];
  end

  assign valid_o = vld[NumW];
  assign side_o  = sd[NumW];
  for (genvar l = 0; l < Lanes; l++) begin : g_q
    assign quo_o[l] = ln[NumW][l].quo;
  end
endmodule

[rtl/core/otp_awb_gain_calc.sv]
// Top level of the OTP AWB gain calculation: front end, ratio divider chain,
// gain divider chain, output register. Depends on oagc_pkg and oagc_div_chain.
// Pipeline: 1 + 30 + 1 + 30 + 1 = 63 register stages.
// Throughput: one transaction per cycle; each of the 60 divider cells retires one bit per lane.
// Reset: valid pipeline and config registers cleared (config to 327/288) asynchronously.
// The receiver cannot stall; every result appears for one cycle with done_o.
module otp_awb_gain_calc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  oagc_pkg::in_t    in_i,
  output logic             done_o,
  output oagc_pkg::out_t   out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [9:0]       cfg_data_i
);
  import oagc_pkg::*;

  localparam int unsigned SideW = 3 + 2;

  logic [9:0] typ_r_q, typ_b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typ_r_q <= TypRedRst;
      typ_b_q <= TypBlueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTypRed:  typ_r_q <= cfg_data_i;
        CfgTypBlue: typ_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // stage 0: group select, join, light products
  logic [1:0] grp;
  logic [2:0] st0;
  logic [9:0] rg, bg, lrg, lbg;
  logic [20:0] prod_r, prod_b;
  always_comb begin
    grp = 2'd0;
    if (in_i.flag_byte[7:6] == 2'b01) grp = 2'd1;
    else if (in_i.flag_byte[5:4] == 2'b01) grp = 2'd2;
    else if (in_i.flag_byte[3:2] == 2'b01) grp = 2'd3;
    if (typ_r_q == '0 || typ_b_q == '0) st0 = StTypUnset;
    else if (grp == 2'd0) st0 = StNoGroup;
    else st0 = StOk;
    rg  = {in_i.red_ratio_high,  in_i.packed_low_bits[7:6]};
    bg  = {in_i.blue_ratio_high, in_i.packed_low_bits[5:4]};
    lrg = {in_i.light_red_high,  in_i.packed_low_bits[3:2]};
    lbg = {in_i.light_blue_high, in_i.packed_low_bits[1:0]};
    prod_r = (lrg != '0) ? 21'(rg) * (21'(lrg) + 21'(LightOffset)) : {1'b0, rg, 10'd0};
    prod_b = (lbg != '0) ? 21'(bg) * (21'(lbg) + 21'(LightOffset)) : {1'b0, bg, 10'd0};
  end

  logic v1_q;
  logic [2:0] st1_q;
  logic [1:0] g1_q;
  logic [10:0] cr_q, cb_q;
  logic [19:0] nr_q, nb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    st1_q <= st0;
    g1_q  <= (st0 == StTypUnset) ? 2'd0 : grp;
    cr_q  <= prod_r[20:10];
    cb_q  <= prod_b[20:10];
    nr_q  <= 20'(typ_r_q) * 20'(RatioScale);
    nb_q  <= 20'(typ_b_q) * 20'(RatioScale);
  end

  logic [2:0] st1;
  assign st1 = (st1_q == StOk && (cr_q == '0 || cb_q == '0)) ? StZeroRatio : st1_q;

  div_lane_t [1:0] l1;
  always_comb begin
    l1[0] = '{num: {nr_q, 10'd0}, den: 20'(cr_q), rem: '0, quo: '0};
    l1[1] = '{num: {nb_q, 10'd0}, den: 20'(cb_q), rem: '0, quo: '0};
    if (cr_q == '0) l1[0].den = 20'd1;
    if (cb_q == '0) l1[1].den = 20'd1;
  end

  logic v2;
  logic [1:0][NumW-1:0] q1;
  logic [SideW-1:0] s2;
  oagc_div_chain #(.Lanes(2), .SideW(SideW)) u_ratio (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v1_q), .lane_i(l1),
    .side_i({st1, g1_q}), .valid_o(v2), .quo_o(q1), .side_o(s2)
  );

  // quotient bits: numerator shifted by 10, so integer part is quo >> 10
  logic [19:0] rgg, bgg, base;
  logic [2:0] st2;
  always_comb begin
    rgg = q1[0][29:10];
    bgg = q1[1][29:10];
    if (rgg < 20'(RatioScale) || bgg < 20'(RatioScale)) base = (rgg < bgg) ? rgg : bgg;
    else base = 20'(RatioScale);
    st2 = (s2[4:2] == StOk && base == '0) ? StZeroBase : s2[4:2];
  end

  logic v3_q;
  logic [2:0] st3_q;
  logic [1:0] g3_q;
  div_lane_t [2:0] l3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2;
  end
  always_ff @(posedge clk_i) begin
    st3_q <= st2;
    g3_q  <= s2[1:0];
    l3_q[0] <= '{num: {rgg, 10'd0}, den: (base == '0) ? 20'd1 : base, rem: '0, quo: '0};
    l3_q[1] <= '{num: 30'(RatioScale) << 10, den: (base == '0) ? 20'd1 : base,
                 rem: '0, quo: '0};
    l3_q[2] <= '{num: {bgg, 10'd0}, den: (base == '0) ? 20'd1 : base, rem: '0, quo: '0};
  end

  logic v4;
  logic [2:0][NumW-1:0] q2;
  logic [SideW-1:0] s4;
  oagc_div_chain #(.Lanes(3), .SideW(SideW)) u_gain (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(v3_q), .lane_i(l3_q),
    .side_i({st3_q, g3_q}), .valid_o(v4), .quo_o(q2), .side_o(s4)
  );

  logic ok;
  assign ok = (s4[4:2] == StOk);
  out_t res;
  always_comb begin
    res.status      = s4[4:2];
    res.group_used  = s4[1:0];
    res.red_gain    = ok ? q2[0] : '0;
    res.green_gain  = ok ? q2[1] : '0;
    res.blue_gain   = ok ? q2[2] : '0;
    res.red_apply   = ok && q2[0] > 30'(UnityGain);
    res.green_apply = ok && q2[1] > 30'(UnityGain);
    res.blue_apply  = ok && q2[2] > 30'(UnityGain);
  end

  logic done_q;
  out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= v4;
  end
  always_ff @(posedge clk_i) out_q <= res;

  assign done_o = done_q;
  assign out_o  = out_q;
endmodule

[rtl/core/oagc_checker.sv]
// Port-level checker for otp_awb_gain_calc, bound to the top level.
// Depends on oagc_pkg.
module oagc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input oagc_pkg::out_t out_o
);
  import oagc_pkg::*;

  a_apply_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (out_o.red_apply || out_o.green_apply || out_o.blue_apply)
      |-> out_o.status == StOk) else $error("apply without ok status");
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_o.status != StOk |-> out_o.red_gain == '0 && out_o.blue_gain == '0)
    else $error("gain nonzero on error");
  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (out_o.status == StTypUnset || out_o.status == StNoGroup)
      |-> out_o.group_used == 2'd0) else $error("group on missing group");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 63)) else $error("result without transaction");
endmodule

bind otp_awb_gain_calc oagc_checker u_oagc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .out_o(out_o)
);

[bench/otp_awb_gain_calc_tb.sv]
// Testbench for otp_awb_gain_calc: directed table plus random transactions, checked
// against an in-bench gain predictor. Depends on oagc_pkg and the block's RTL.
module otp_awb_gain_calc_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oagc_pkg::*;

  localparam int unsigned Latency  = 64;
  localparam int unsigned MaxCycles = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_i = '0;
  logic done_o;
  out_t out_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CfgTypRed;
  logic [9:0] cfg_data_i = '0;

  otp_awb_gain_calc dut (.*);

  always #5 clk_i = ~clk_i;

  logic [9:0] typ_red, typ_blue;
  out_t pending_gains[$];
  int   errors = 0;
  int   cycles = 0;
  int   idle_pct = 0;

  function automatic logic [9:0] rebuild10(logic [7:0] hi, logic [7:0] lo, int sh);
    rebuild10 = {hi, lo[sh +: 2]};
  endfunction

  function automatic logic [31:0] light_fix(logic [9:0] r, logic [9:0] l);
    light_fix = (l != 0) ? 32'(r) * (32'(l) + 32'd512) / 32'd1024 : 32'(r);
  endfunction

  function automatic out_t predict_gains(in_t t);
    out_t o;
    logic [31:0] rg, bg, rgg, bgg, base;
    logic [1:0]  grp;
    o = '0;
    grp = 2'd0;
    if (typ_red == 0 || typ_blue == 0) begin
      o.status = StTypUnset;
    end else begin
      if (t.flag_byte[7:6] == 2'b01) grp = 2'd1;
      else if (t.flag_byte[5:4] == 2'b01) grp = 2'd2;
      else if (t.flag_byte[3:2] == 2'b01) grp = 2'd3;
      o.group_used = grp;
      if (grp == 0) begin
        o.status = StNoGroup;
      end else begin
        rg = light_fix(rebuild10(t.red_ratio_high, t.packed_low_bits, 6),
                       rebuild10(t.light_red_high, t.packed_low_bits, 2));
        bg = light_fix(rebuild10(t.blue_ratio_high, t.packed_low_bits, 4),
                       rebuild10(t.light_blue_high, t.packed_low_bits, 0));
        if (rg == 0 || bg == 0) begin
          o.status = StZeroRatio;
        end else begin
          rgg = 32'(typ_red) * 32'd1000 / rg;
          bgg = 32'(typ_blue) * 32'd1000 / bg;
          base = (rgg < 1000 || bgg < 1000) ? ((rgg < bgg) ? rgg : bgg) : 32'd1000;
          if (base == 0) begin
            o.status = StZeroBase;
          end else begin
            o.status = StOk;
            o.red_gain   = 30'(32'd1024 * rgg / base);
            o.green_gain = 30'(32'd1024000 / base);
            o.blue_gain  = 30'(32'd1024 * bgg / base);
            o.red_apply   = o.red_gain > 1024;
            o.green_apply = o.green_gain > 1024;
            o.blue_apply  = o.blue_gain > 1024;
          end
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_gains.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_o);
        errors <= errors + 1;
      end else if (pending_gains[0] !== out_o) begin
        $display("%0t mismatch expected %p actual %p", $time, pending_gains[0], out_o);
        errors <= errors + 1;
        void'(pending_gains.pop_front());
      end else begin
        void'(pending_gains.pop_front());
      end
    end
  end

  task automatic write_typical(logic idx, logic [9:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgTypRed) typ_red = val;
    else typ_blue = val;
  endtask

  task automatic drain();
    while (pending_gains.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // fixed expectations only where obvious; others predicted (use_pred)
  task automatic issue(in_t t, bit use_pred, out_t fixed);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_gains.push_back(use_pred ? predict_gains(t) : fixed);
  endtask

  function automatic in_t rand_item();
    in_t t;
    t = 48'({$urandom, $urandom});
    case ($urandom_range(9))
      0: ;
      1, 2: t.flag_byte = {2'b01, 6'($urandom)};
      3, 4: t.flag_byte = {2'b00, 2'b01, 4'($urandom)};
      5: t.flag_byte = {2'b11, 2'b10, 2'b01, 2'($urandom)};
      default: t.flag_byte = {2'($urandom), 2'($urandom), 2'b01, 2'($urandom)};
    endcase
    if ($urandom_range(7) == 0) t.light_red_high = 0;
    if ($urandom_range(7) == 0) t.light_blue_high = 0;
    return t;
  endfunction

  typedef struct {
    in_t  stim;
    bit   use_pred;
    out_t gains;
  } vec_t;

  initial begin
    vec_t table_v[$];
    out_t unset_o, nogrp_o, zero_o;
    int phase;
    unset_o = '0; unset_o.status = StTypUnset;
    nogrp_o = '0; nogrp_o.status = StNoGroup;
    zero_o  = '0; zero_o.status = StZeroRatio; zero_o.group_used = 2'd1;
    typ_red = TypRedRst;
    typ_blue = TypBlueRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    table_v = '{
      '{48'h00_80_80_00_00_00, 0, nogrp_o},
      '{48'hFF_FF_FF_FF_FF_FF, 0, nogrp_o},
      '{48'hAA_80_80_00_00_00, 0, nogrp_o},
      '{48'h40_00_00_00_00_00, 0, zero_o},
      '{48'h40_52_48_00_00_00, 1, '0},
      '{48'h10_52_48_00_00_00, 1, '0},
      '{48'h04_52_48_00_00_00, 1, '0},
      '{48'h7F_FF_FF_FF_FF_FF, 1, '0},
      '{48'h40_01_FF_00_00_00, 1, '0},
      '{48'h40_FF_01_00_00_00, 1, '0},
      '{48'h40_00_00_FF_FF_FF, 1, '0},
      '{48'h40_00_20_00_00_40, 1, '0},
      '{48'h40_80_80_01_00_00, 1, '0},
      '{48'h40_00_00_00_00_C0, 1, '0}
    };
    foreach (table_v[i]) issue(table_v[i].stim, table_v[i].use_pred, table_v[i].gains);
    start <= 1'b0;
    drain();

    // extremes: unset typical, then max/min typicals
    write_typical(CfgTypRed, 10'd0);
    issue(48'h40_52_48_00_00_00, 0, unset_o);
    start <= 1'b0;
    drain();
    write_typical(CfgTypRed, 10'd1023);
    write_typical(CfgTypBlue, 10'd0);
    issue(48'h40_52_48_00_00_00, 0, unset_o);
    start <= 1'b0;
    drain();
    write_typical(CfgTypBlue, 10'd1);
    issue(48'h40_FF_FF_FF_FF_FF, 1, '0);
    issue(48'h40_01_01_00_00_00, 1, '0);
    start <= 1'b0;
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      case (phase)
        0: begin write_typical(CfgTypRed, 10'd1); write_typical(CfgTypBlue, 10'd1023); end
        1: begin write_typical(CfgTypRed, 10'd1023); write_typical(CfgTypBlue, 10'd1023); end
        2: begin write_typical(CfgTypRed, TypRedRst); write_typical(CfgTypBlue, TypBlueRst); end
        default: begin
          write_typical(CfgTypRed, 10'($urandom_range(1, 1023)));
          write_typical(CfgTypBlue, 10'($urandom_range(1, 1023)));
        end
      endcase
      repeat (240) issue(rand_item(), 1, '0);
      start <= 1'b0;
      drain();
    end

    if (errors == 0 && pending_gains.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
